>>> sv/rt_pkg.sv
// Package: shared constants, codes and structs of the retransmission tracker
`default_nettype none
package rt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int RETRY_W     = 8;
    localparam int CMD_W       = 2;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = TIMEOUT_W'(250);
    localparam logic [RETRY_W-1:0]   MAX_RETRIES_RESET = RETRY_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = CFG_IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND    = 2'd0,
        CMD_CONFIRM = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_RESEND  = 2'd0,
        KIND_GAVE_UP = 2'd1,
        KIND_DROPPED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  stamp;
        logic [RETRY_W-1:0] retries;
    } rt_entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             valid;
        rt_entry_t        data;
    } rt_wr_t;

    typedef struct packed {
        logic [TIME_W-1:0]    now;
        logic [ID_W-1:0]      id;
        logic [TIMEOUT_W-1:0] timeout;
        logic [RETRY_W-1:0]   max_retries;
    } rt_op_t;

    typedef struct packed {
        logic               due;
        logic               exhausted;
        logic               match;
        logic [RETRY_W-1:0] retries_inc;
    } rt_flags_t;

endpackage
`default_nettype wire

>>> sv/rt_item_if.sv
// Interfaces: input item, result and configuration write channels
`default_nettype none
interface rt_item_if import rt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   msg_id;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output cmd, output msg_id, output now_ms, input ready);
    modport sink   (input valid, input cmd, input msg_id, input now_ms, output ready);
endinterface

interface rt_result_if import rt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   out_id;
    logic              last;

    modport source (output valid, output kind, output out_id, output last, input ready);
    modport sink   (input valid, input kind, input out_id, input last, output ready);
endinterface

interface rt_cfg_if import rt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/retransmission_tracker.sv
// Top level: retransmission timer table with sequencer, compare unit and entry table
// An item passes a scan of all TABLE_DEPTH slots and a flush state; a send also passes a
// table write state between them. Results leave through a one-beat output register.
// New items are taken only in idle, after the last one is through; the scan checks one slot
// per cycle through the shared compare unit, unless a tick waits on a stalled result.
// Reset: all slots free, timeout_ms 250, max_retries 3; no clearing pass is needed.
`default_nettype none
module retransmission_tracker
    import rt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rt_item_if.sink     item,
    rt_result_if.source result,
    rt_cfg_if.sink      cfg
);

    rt_wr_t           wr;
    logic [IDX_W-1:0] rd_idx;
    rt_entry_t        rd_entry;
    logic             rd_valid;
    rt_op_t           op;
    rt_flags_t        flags;

    rt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .result   (result),
        .cfg      (cfg),
        .wr       (wr),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .op       (op),
        .flags    (flags)
    );

    rt_unit u_unit (
        .op    (op),
        .entry (rd_entry),
        .flags (flags)
    );

    rt_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

endmodule
`default_nettype wire

>>> sv/rt_table.sv
// Entry table: valid bits, ids, time stamps and retry counts of all slots
`default_nettype none
module rt_table
    import rt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rt_wr_t           wr,
    input  wire logic [IDX_W-1:0] rd_idx,
    output rt_entry_t             rd_entry,
    output logic                  rd_valid
);

    logic [TABLE_DEPTH-1:0] valid_reg;
    rt_entry_t              entry_reg [TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.valid)
        begin
            entry_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_entry = entry_reg[rd_idx];
    assign rd_valid = valid_reg[rd_idx];

endmodule
`default_nettype wire

>>> sv/rt_unit.sv
// Shared compare unit: age check, retry limit, id match and retry increment
`default_nettype none
module rt_unit
    import rt_pkg::*;
(
    input  wire rt_op_t    op,
    input  wire rt_entry_t entry,
    output rt_flags_t      flags
);

    logic [TIME_W-1:0] age;

    always_comb
    begin
        age               = op.now - entry.stamp;
        flags.due         = (age >= TIME_W'(op.timeout));
        flags.exhausted   = (entry.retries >= op.max_retries);
        flags.match       = (entry.id == op.id);
        flags.retries_inc = entry.retries + RETRY_W'(1);
    end

endmodule
`default_nettype wire

>>> sv/rt_ctrl.sv
// Sequencer: slot scan, table updates, held result and result register
`default_nettype none
module rt_ctrl
    import rt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rt_item_if.sink         item,
    rt_result_if.source     result,
    rt_cfg_if.sink          cfg,
    output rt_wr_t          wr,
    output logic [IDX_W-1:0] rd_idx,
    input  wire rt_entry_t  rd_entry,
    input  wire logic       rd_valid,
    output rt_op_t          op,
    input  wire rt_flags_t  flags
);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [RETRY_W-1:0]   max_retries_reg;

    logic                 hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;

    logic                 pend_valid_reg, pend_valid_next;
    kind_t                pend_kind_reg, pend_kind_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 out_free;
    logic                 adv;
    logic                 last_slot;

    assign item.ready    = (state_reg == ST_IDLE);
    assign accept        = item.valid && item.ready;
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_valid_reg || result.ready;
    assign last_slot     = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign rd_idx        = idx_reg;

    assign result.valid  = out_valid_reg;
    assign result.kind   = out_kind_reg;
    assign result.out_id = out_id_reg;
    assign result.last   = out_last_reg;

    assign op.now         = now_reg;
    assign op.id          = id_reg;
    assign op.timeout     = timeout_reg;
    assign op.max_retries = max_retries_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_SEND || item.cmd == CMD_CONFIRM
                               || item.cmd == CMD_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (adv && last_slot)
                begin
                    state_next = (cmd_reg == CMD_SEND) ? ST_WRITE : ST_FLUSH;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        adv             = 1'b0;
        wr              = '0;
        idx_next        = idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next        = '0;
                hit_found_next  = 1'b0;
                free_found_next = 1'b0;
            end
            ST_SCAN:
            begin
                unique case (cmd_reg)
                    CMD_SEND:
                    begin
                        adv = 1'b1;
                        if (rd_valid && flags.match && !hit_found_reg)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = idx_reg;
                        end
                        if (!rd_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    CMD_CONFIRM:
                    begin
                        adv = 1'b1;
                        if (rd_valid && flags.match)
                        begin
                            wr.en    = 1'b1;
                            wr.idx   = idx_reg;
                            wr.valid = 1'b0;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (rd_valid && flags.due)
                        begin
                            // hold the slot while the held result cannot move on
                            if (!pend_valid_reg || out_free)
                            begin
                                adv = 1'b1;
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_kind_next  = pend_kind_reg;
                                    out_id_next    = pend_id_reg;
                                    out_last_next  = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_id_next    = rd_entry.id;
                                wr.en           = 1'b1;
                                wr.idx          = idx_reg;
                                if (flags.exhausted)
                                begin
                                    pend_kind_next = KIND_GAVE_UP;
                                    wr.valid       = 1'b0;
                                end
                                else
                                begin
                                    pend_kind_next     = KIND_RESEND;
                                    wr.valid           = 1'b1;
                                    wr.data.id         = rd_entry.id;
                                    wr.data.stamp      = now_reg;
                                    wr.data.retries    = flags.retries_inc;
                                end
                            end
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        adv = 1'b1;
                    end
                endcase
                if (adv)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_WRITE:
            begin
                if (hit_found_reg || free_found_reg)
                begin
                    wr.en           = 1'b1;
                    wr.idx          = hit_found_reg ? hit_idx_reg : free_idx_reg;
                    wr.valid        = 1'b1;
                    wr.data.id      = id_reg;
                    wr.data.stamp   = now_reg;
                    wr.data.retries = '0;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_kind_next  = KIND_DROPPED;
                    pend_id_next    = id_reg;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_id_next     = pend_id_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            timeout_reg     <= TIMEOUT_RESET;
            max_retries_reg <= MAX_RETRIES_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_TIMEOUT)
                begin
                    timeout_reg <= cfg.data[TIMEOUT_W-1:0];
                end
                if (cfg.index == CFG_MAX_RETRIES)
                begin
                    max_retries_reg <= cfg.data[RETRY_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
        if (accept)
        begin
            cmd_reg <= item.cmd;
            id_reg  <= item.msg_id;
            now_reg <= item.now_ms;
        end
    end

    a_wr_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_SCAN || state_reg == ST_WRITE))
        else $error("table written outside scan or write");

    a_pend_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> state_reg != ST_IDLE)
        else $error("held result left behind in idle");

    a_send_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> !pend_valid_reg)
        else $error("held result present at send write");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && state_next == ST_IDLE) |=> !pend_valid_reg)
        else $error("held result not delivered at end of item");

endmodule
`default_nettype wire
